// File: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: the operation codes and
// the control word that the sequencer hands to the serial modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Which product the multiplier forms. The scanned operand is always the
  // running square; the added operand is selected by the code.
  typedef enum logic [1:0] {
    MOP_REDUCE = 2'd0,  // 1 * square: reduces the raw base modulo m
    MOP_ACC    = 2'd1,  // accumulator * square
    MOP_SQUARE = 2'd2   // square * square
  } mexp_op_t;

  typedef struct packed {
    logic     start;
    mexp_op_t op;
  } mexp_mul_ctrl_t;

endpackage

// File: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary modular exponentiation over OPERAND_WIDTH-bit operands.
// ----------------------------------------------------------------------------
// Each transfer on the input carries base, exponent and modulus; one result
// transfer follows with base^exponent mod modulus. A zero modulus gives
// result 0 with error set; a zero exponent gives 1, unreduced, even for a
// modulus of one. Both special cases go straight to the finishing state.
// Otherwise the base is first reduced, then each exponent bit up to the
// highest set one costs a multiply into the accumulator where the bit is
// set and a squaring where a higher bit remains. Every product goes through
// one serial modular multiplier that retires one multiplier bit per cycle.
// The block works on one item at a time; input stall is high from the
// accepting edge until the result sits in the output register, which holds
// it until the consumer takes it, so a new item may be taken while an
// earlier result still waits.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] out_result,
  output logic                     out_error
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULACC,
    ST_SQUARE,
    ST_FINISH
  } state_t;

  state_t         state_r;
  logic [W-1:0]   sq_r;      // running square (raw base before reduction)
  logic [W-1:0]   acc_r;     // accumulator, and the pending result
  logic [W-1:0]   exp_r;     // remaining exponent, shifted right per step
  logic [W-1:0]   mod_r;
  logic           err_r;
  mexp_mul_ctrl_t ctrl_r;
  logic           out_valid_r;
  logic [W-1:0]   out_result_r;
  logic           out_error_r;

  logic [W-1:0]   mul_product;
  logic           mul_done;
  logic           in_xfer;

  assign in_xfer = in_valid && !in_stall;

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_r),
    .acc     (acc_r),
    .sq      (sq_r),
    .modulus (mod_r),
    .product (mul_product),
    .done    (mul_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ctrl_r       <= '{start: 1'b0, op: MOP_REDUCE};
      sq_r         <= '0;
      acc_r        <= {{(W-1){1'b0}}, 1'b1};
      exp_r        <= '0;
      mod_r        <= '0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_result_r <= '0;
      out_error_r  <= 1'b0;
    end else begin
      // load the output register from the finishing state; otherwise drop
      // the held result once the consumer takes it
      if (state_r == ST_FINISH && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // start is a single-cycle pulse: every branch that starts no product
      // clears it
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sq_r  <= in_base;
            exp_r <= in_exponent;
            mod_r <= in_modulus;
            if (in_modulus == '0) begin
              // zero modulus: flag it, result 0, exponent ignored
              acc_r        <= '0;
              err_r        <= 1'b1;
              ctrl_r.start <= 1'b0;
              state_r      <= ST_FINISH;
            end else begin
              acc_r <= {{(W-1){1'b0}}, 1'b1};
              err_r <= 1'b0;
              if (in_exponent == '0) begin
                ctrl_r.start <= 1'b0;
                state_r      <= ST_FINISH;
              end else begin
                ctrl_r  <= '{start: 1'b1, op: MOP_REDUCE};
                state_r <= ST_REDUCE;
              end
            end
          end else begin
            ctrl_r.start <= 1'b0;
          end
        end

        ST_REDUCE: begin
          if (mul_done) begin
            sq_r <= mul_product;
            if (exp_r[0]) begin
              ctrl_r  <= '{start: 1'b1, op: MOP_ACC};
              state_r <= ST_MULACC;
            end else begin
              ctrl_r  <= '{start: 1'b1, op: MOP_SQUARE};
              state_r <= ST_SQUARE;
            end
          end else begin
            ctrl_r.start <= 1'b0;
          end
        end

        ST_MULACC: begin
          if (mul_done) begin
            acc_r <= mul_product;
            // skip the final squaring: nothing above this bit uses it
            if (exp_r[W-1:1] == '0) begin
              ctrl_r.start <= 1'b0;
              state_r      <= ST_FINISH;
            end else begin
              ctrl_r  <= '{start: 1'b1, op: MOP_SQUARE};
              state_r <= ST_SQUARE;
            end
          end else begin
            ctrl_r.start <= 1'b0;
          end
        end

        ST_SQUARE: begin
          if (mul_done) begin
            sq_r  <= mul_product;
            exp_r <= {1'b0, exp_r[W-1:1]};
            // a square is only started with a set bit above, so the next
            // step always exists; advance to it on bit one
            if (exp_r[1]) begin
              ctrl_r  <= '{start: 1'b1, op: MOP_ACC};
              state_r <= ST_MULACC;
            end else begin
              ctrl_r  <= '{start: 1'b1, op: MOP_SQUARE};
              state_r <= ST_SQUARE;
            end
          end else begin
            ctrl_r.start <= 1'b0;
          end
        end

        ST_FINISH: begin
          ctrl_r.start <= 1'b0;
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_result_r <= acc_r;
            out_error_r  <= err_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          ctrl_r.start <= 1'b0;
          state_r      <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule

// File: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Serial modular multiplier: scans the multiplier one bit per cycle, MSB
// first, doubling and conditionally adding modulo m with a single
// add-compare-select step.
// ----------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mexp_mul_ctrl_t ctrl,
  input  logic [W-1:0]   acc,
  input  logic [W-1:0]   sq,
  input  logic [W-1:0]   modulus,
  output logic [W-1:0]   product,
  output logic           done
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W-1:0]  a_sel;
  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  t_sub1;
  logic [W+1:0]  t_sub2;
  logic [W-1:0]  r_nxt;

  always_comb begin
    unique case (ctrl.op)
      MOP_REDUCE: a_sel = {{(W-1){1'b0}}, 1'b1};
      MOP_ACC:    a_sel = acc;
      MOP_SQUARE: a_sel = sq;
      default:    a_sel = sq;
    endcase
  end

  // 2r + bit*a stays below 3m, so one of three candidates is the residue
  always_comb begin
    t      = {1'b0, r_r, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : {(W+2){1'b0}});
    m1     = {2'b00, m_r};
    m2     = {1'b0, m_r, 1'b0};
    t_sub1 = t - m1;
    t_sub2 = t - m2;
    if (t >= m2) begin
      r_nxt = t_sub2[W-1:0];
    end else if (t >= m1) begin
      r_nxt = t_sub1[W-1:0];
    end else begin
      r_nxt = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (ctrl.start) begin
        a_r    <= a_sel;
        b_r    <= sq;
        m_r    <= modulus;
        r_r    <= '0;
        cnt_r  <= CW'(W - 1);
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        r_r <= r_nxt;
        b_r <= {b_r[W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_r - CW'(1);
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign product = r_r;
  assign done    = done_r;

endmodule

// File: tb/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the 64-bit right-to-left modular exponentiator.
// ----------------------------------------------------------------------------
// Operand sets are offered on the input channel and predicted by a scoreboard
// that forms base^exponent mod modulus with exact 128-bit products. Every
// result transfer is compared field by field with the oldest prediction. A
// directed block covers the zero modulus, the unreduced zero exponent, a
// modulus of one, bases not below the modulus and full-width operands. A
// random block follows, mostly with short exponents to keep the run brief.
// Both sides idle at random, with one quiet stretch, and the receiver holds
// off once for long enough that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = 64;
  localparam int RANDOM_ITEMS = 82;
  localparam int HOLD_AT      = 25;        // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 20000;
  localparam int DRAIN_CYCLES = 200;
  // Generous cap on the whole run, well above the worst case.
  localparam int LIMIT_CYCLES = 4000000;

  // Scoreboard: predicts each power and checks results in order.
  class power_checker;
    typedef struct {
      bit [W-1:0] value;
      bit         error;
    } power_t;

    power_t     expected[$];
    bit [W-1:0] square;
    bit [W-1:0] acc;
    bit [W-1:0] rem_exp;
    bit [W-1:0] held_mod;
    int         failures;
    int         checked;
    int         zero_moduli;
    int         zero_exponents;

    function new();
      square   = '0;
      acc      = 1;
      rem_exp  = '0;
      held_mod = '0;
    endfunction

    // Exact (a * b) mod held_mod through a double-width product.
    function bit [W-1:0] mul_mod(bit [W-1:0] a, bit [W-1:0] b);
      bit [2*W-1:0] wide;
      wide = {{W{1'b0}}, a} * {{W{1'b0}}, b};
      wide = wide % {{W{1'b0}}, held_mod};
      return wide[W-1:0];
    endfunction

    function void note_operands(bit [W-1:0] b, bit [W-1:0] e, bit [W-1:0] m);
      power_t p;
      held_mod = m;
      rem_exp  = e;
      acc      = 1;
      if (m == 0) begin
        // Zero modulus is flagged before anything else is looked at.
        square      = b;
        p.value     = '0;
        p.error     = 1'b1;
        zero_moduli++;
      end else begin
        if (e == 0) zero_exponents++;
        square = b % m;
        while (rem_exp != 0) begin
          if (rem_exp[0]) acc = mul_mod(acc % held_mod, square);
          square  = mul_mod(square, square);
          rem_exp = rem_exp >> 1;
        end
        // A zero exponent leaves the accumulator at 1, unreduced.
        p.value = acc;
        p.error = 1'b0;
      end
      expected.push_back(p);
    endfunction

    function void check_power(bit [W-1:0] r, bit err);
      power_t p;
      if (expected.size() == 0) begin
        $error("result transfer with nothing outstanding: result %h error %0b", r, err);
        failures++;
        return;
      end
      p = expected.pop_front();
      checked++;
      if (r !== p.value) begin
        $error("field result: expected %h actual %h", p.value, r);
        failures++;
      end
      if (err !== p.error) begin
        $error("field error: expected %0b actual %0b", p.error, err);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [W-1:0] in_base;
  logic [W-1:0] in_exponent;
  logic [W-1:0] in_modulus;
  logic         out_valid;
  logic         out_stall;
  logic [W-1:0] out_result;
  logic         out_error;

  power_checker sb;
  bit           quiet;        // no idling on either side while set
  int           cycle_count;
  int           wide_exps;
  int           items_sent;

  modular_exponentiation #(
    .OPERAND_WIDTH(W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .in_modulus (in_modulus),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .out_error  (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold every input at a known value from time zero.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_base     = '0;
    in_exponent = '0;
    in_modulus  = '0;
    out_stall   = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Abandon the run if it overstays the limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Observe both channels at the rising edge; record each transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_operands(in_base, in_exponent, in_modulus);
      if (out_valid && !out_stall) sb.check_power(out_result, out_error);
    end
  end

  function automatic bit [W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one operand set, idling first at random, and hold it until taken.
  task automatic offer(input bit [W-1:0] b, input bit [W-1:0] e, input bit [W-1:0] m);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 24) begin
      // Drop valid and scramble the payload while idle.
      in_valid    <= 1'b0;
      in_base     <= rand64();
      in_exponent <= rand64();
      in_modulus  <= rand64();
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    in_modulus  <= m;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Receiver: stall at random, and once hold off long enough to fill the block.
  initial begin : sink
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && sb.checked >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
      end
    end
  end

  initial begin : stimulus
    bit [W-1:0] b, e, m;
    int         kind, w;
    sb        = new();
    quiet     = 1'b0;
    wide_exps = 0;
    items_sent = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero modulus, whatever the other operands are.
    offer('0, '0, '0);
    offer('1, '1, '0);
    // Zero exponent gives 1 unreduced, including modulus one.
    offer(64'd5, '0, 64'd1);
    offer('1, '0, '1);
    // Modulus one with a live exponent reduces to zero.
    offer('1, 64'd1, 64'd1);
    // Bases at or above the modulus are reduced first; a zero base gives zero.
    offer('1, 64'd1, 64'd7);
    offer(64'd12345, 64'd3, 64'd12345);
    offer(64'd7, 64'd10, 64'd2);
    offer('0, 64'd5, 64'd13);
    // Wide exponents and moduli, several at full width.
    offer(64'd1, '1, '1);
    offer('1, '1, '1);
    offer(64'hFFFF_FFFF_FFFF_FFFE, '1, '1);
    offer(64'd2, 64'd64, '1);
    offer(64'd3, 64'd1000, 64'd1000000007);
    offer('1, 64'd2, 64'h8000_0000_0000_0000);
    offer(64'd12345678, 64'd65537, 64'hFFFF_FFFF_FFFF_FFC5);
    offer(64'd2, 64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC5);
    offer(64'd3, 64'h8000_0000_0000_0000, 64'hDEAD_BEEF_CAFE_F00D);

    // Random: mostly short exponents, a tenth at full width.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 60 && i < 80);
      kind  = $urandom_range(99);
      if (kind < 60) m = rand64();
      else if (kind < 85) m = 64'($urandom_range(1000, 1));
      else begin
        w = $urandom_range(W, 1);
        m = rand64() >> (W - w);
      end
      if ($urandom_range(99) < 5) m = '0;
      if (m == 0 && kind < 95 && kind >= 90) m = 64'd1;
      b = ($urandom_range(99) < 70) ? rand64() : 64'($urandom_range(1000));
      kind = $urandom_range(99);
      if (kind < 5) e = '0;
      else if (kind < 15) begin
        e = rand64();
        wide_exps++;
      end else begin
        w = $urandom_range(16, 1);
        e = rand64() & ((64'd1 << w) - 64'd1);
      end
      offer(b, e, m);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every prediction to be met, then allow stray transfers to show.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d operand sets: %0d zero moduli, %0d zero exponents,",
             items_sent, sb.zero_moduli, sb.zero_exponents);
    $display("%0d random wide exponents; %0d results compared, %0d mismatches, %0d left.",
             wide_exps, sb.checked, sb.failures, sb.outstanding());
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
